// File: rtl/ws2_pkg.sv
// Shared types and constants for the WS2812 pulse encoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ws2_pkg;

    // Bits per color channel and per packed color word.
    localparam int CHAN_BITS  = 8;
    localparam int COLOR_BITS = 3 * CHAN_BITS;

    // Tick register widths.
    localparam int BIT_TICK_W = 12;
    localparam int GAP_TICK_W = 16;

    // Segments per frame: two per bit and one latch gap.
    localparam int SEG_COUNT = 2 * COLOR_BITS + 1;
    localparam int SEG_W     = $clog2(SEG_COUNT);
    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEG_COUNT - 1);

    // Dimming by ten as a multiply by 205 and a shift right by 11.
    localparam int DIM_MUL_W = 8;
    localparam logic [DIM_MUL_W-1:0] DIM_MUL = 8'd205;
    localparam int DIM_SHIFT = 11;
    localparam int DIM_Q_W   = CHAN_BITS + DIM_MUL_W - DIM_SHIFT;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GAP_TICK_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ONE_HIGH  = 3'd0,
        REG_ONE_LOW   = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ZERO_LOW  = 3'd3,
        REG_LATCH_GAP = 3'd4
    } cfg_reg_t;

    // Timing registers as seen by the serializer.
    typedef struct packed {
        logic [BIT_TICK_W-1:0] one_high;
        logic [BIT_TICK_W-1:0] one_low;
        logic [BIT_TICK_W-1:0] zero_high;
        logic [BIT_TICK_W-1:0] zero_low;
        logic [GAP_TICK_W-1:0] latch_gap;
    } timing_t;

    // Dimmed color in send order.
    typedef struct packed {
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] blue;
    } color_t;

endpackage

`default_nettype wire

// File: rtl/ws2_front.sv
// Front end: accepts a color transfer and dims each channel by ten.
// Depends on ws2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ws2_front
    import ws2_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [CHAN_BITS-1:0] s_red_level,
    input  wire logic [CHAN_BITS-1:0] s_green_level,
    input  wire logic [CHAN_BITS-1:0] s_blue_level,
    output      logic                 q_valid,
    input  wire logic                 q_ready,
    output      color_t               q_color
);

    logic   valid_reg;
    logic   valid_next;
    color_t color_reg;
    color_t color_dim;

    // Integer division by ten, exact for all 8-bit values.
    function automatic logic [CHAN_BITS-1:0] dim10(input logic [CHAN_BITS-1:0] x);
        logic [CHAN_BITS+DIM_MUL_W-1:0] prod;
        prod = (CHAN_BITS+DIM_MUL_W)'(x) * (CHAN_BITS+DIM_MUL_W)'(DIM_MUL);
        return CHAN_BITS'(prod[CHAN_BITS+DIM_MUL_W-1:DIM_SHIFT]);
    endfunction

    assign color_dim.green = dim10(s_green_level);
    assign color_dim.red   = dim10(s_red_level);
    assign color_dim.blue  = dim10(s_blue_level);

    // The stage register takes a transfer when empty or emptying this cycle.
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            color_reg <= color_dim;
        end
    end

    assign q_valid = valid_reg;
    assign q_color = color_reg;

endmodule

`default_nettype wire

// File: rtl/ws2_fifo.sv
// Two-entry queue of dimmed colors between the front end and the serializer.
// Depends on ws2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ws2_fifo
    import ws2_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_valid,
    output      logic   wr_ready,
    input  wire color_t wr_color,
    output      logic   rd_valid,
    input  wire logic   rd_ready,
    output      color_t rd_color
);

    color_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_color = mem[rd_ptr_reg];

    // Occupancy tracks pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_color;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ws2_serial.sv
// Back end: expands one dimmed color into 49 pulse segments, one per cycle
// while m_ready is high. Depends on ws2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ws2_serial
    import ws2_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire timing_t               timing,
    input  wire logic                  q_valid,
    output      logic                  q_ready,
    input  wire color_t                q_color,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic                  m_line_level,
    output      logic [GAP_TICK_W-1:0] m_segment_ticks,
    output      logic                  m_frame_end
);

    logic [COLOR_BITS-1:0] data_reg;
    logic [SEG_W-1:0]      seg_reg;
    logic                  busy_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  level_reg;
    logic [GAP_TICK_W-1:0] ticks_reg;
    logic                  end_reg;

    logic                  advance;
    logic                  last_seg;
    logic                  cur_bit;
    logic                  seg_level;
    logic [BIT_TICK_W-1:0] bit_ticks;
    logic [GAP_TICK_W-1:0] seg_ticks;

    // A segment is issued whenever the output register is free or drained.
    assign advance  = busy_reg && (!out_valid_reg || m_ready);
    assign last_seg = (seg_reg == LAST_SEG);
    assign q_ready  = !busy_reg || (advance && last_seg);
    assign cur_bit  = data_reg[COLOR_BITS-1];

    // Even segments but the last are high bit halves, odd ones low halves.
    assign seg_level = !last_seg && !seg_reg[0];

    // Pick the tick count; a zero register counts as one tick.
    always_comb begin
        if (seg_reg[0]) begin
            bit_ticks = cur_bit ? timing.one_low : timing.zero_low;
        end else begin
            bit_ticks = cur_bit ? timing.one_high : timing.zero_high;
        end
        if (last_seg) begin
            seg_ticks = (timing.latch_gap == '0) ? GAP_TICK_W'(1) : timing.latch_gap;
        end else begin
            seg_ticks = (bit_ticks == '0) ? GAP_TICK_W'(1) : GAP_TICK_W'(bit_ticks);
        end
    end

    // Sequencer: segment counter and shift register of color bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seg_reg  <= '0;
        end else if (q_valid && q_ready) begin
            busy_reg <= 1'b1;
            seg_reg  <= '0;
        end else if (advance && last_seg) begin
            busy_reg <= 1'b0;
        end else if (advance) begin
            seg_reg <= seg_reg + SEG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            data_reg <= q_color;
        end else if (advance && seg_reg[0]) begin
            data_reg <= {data_reg[COLOR_BITS-2:0], 1'b0};
        end
    end

    // Output register holds a segment until its transfer.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            level_reg <= seg_level;
            ticks_reg <= seg_ticks;
            end_reg   <= last_seg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_line_level    = level_reg;
    assign m_segment_ticks = ticks_reg;
    assign m_frame_end     = end_reg;

endmodule

`default_nettype wire

// File: rtl/ws2812_pulse_encoder.sv
// WS2812 pulse encoder top level: timing registers, front end, queue, serializer.
// Depends on ws2_pkg, ws2_front, ws2_fifo and ws2_serial.
//
// Usage:
//   Each transfer on the s_ channel is one RGB color. Every channel is divided
//   by ten, then sent green, red, blue, most significant bit first. Each bit
//   gives a high and a low segment on the m_ channel, with lengths taken from
//   the one-bit or zero-bit timing registers; a low latch segment with
//   m_frame_end set closes each frame, 49 segments in all.
//   Timing registers are written through cfg_we, cfg_addr and cfg_wdata; the
//   user must write them only while the encoder is idle, as the block does
//   not enforce this. Writes to unused addresses are ignored.
// Path: a color passes the front stage register, the queue, the serializer's
//   sequencer and its output register before its first segment is on m_.
// Throughput: the serializer sets one segment per cycle while m_ready is high;
//   the front stage and a two-entry queue keep accepting colors as it works.
// Reset: aresetn low clears all queues and restores the timing registers to
//   their 16 MHz defaults. When m_ready is low the current segment holds and
//   the serializer waits; the queue then fills and s_ready falls.
`timescale 1ns / 1ps
`default_nettype none

module ws2812_pulse_encoder
    import ws2_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [CHAN_BITS-1:0]  s_red_level,
    input  wire logic [CHAN_BITS-1:0]  s_green_level,
    input  wire logic [CHAN_BITS-1:0]  s_blue_level,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic                  m_line_level,
    output      logic [GAP_TICK_W-1:0] m_segment_ticks,
    output      logic                  m_frame_end
);

    timing_t timing_reg;
    logic    fq_valid;
    logic    fq_ready;
    color_t  fq_color;
    logic    qs_valid;
    logic    qs_ready;
    color_t  qs_color;

    // Timing register file with write decode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.one_high  <= BIT_TICK_W'(11);
            timing_reg.one_low   <= BIT_TICK_W'(10);
            timing_reg.zero_high <= BIT_TICK_W'(6);
            timing_reg.zero_low  <= BIT_TICK_W'(13);
            timing_reg.latch_gap <= GAP_TICK_W'(800);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ONE_HIGH:  timing_reg.one_high  <= cfg_wdata[BIT_TICK_W-1:0];
                REG_ONE_LOW:   timing_reg.one_low   <= cfg_wdata[BIT_TICK_W-1:0];
                REG_ZERO_HIGH: timing_reg.zero_high <= cfg_wdata[BIT_TICK_W-1:0];
                REG_ZERO_LOW:  timing_reg.zero_low  <= cfg_wdata[BIT_TICK_W-1:0];
                REG_LATCH_GAP: timing_reg.latch_gap <= cfg_wdata[GAP_TICK_W-1:0];
                default: ;
            endcase
        end
    end

    ws2_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red_level   (s_red_level),
        .s_green_level (s_green_level),
        .s_blue_level  (s_blue_level),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_color       (fq_color)
    );

    ws2_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_color (fq_color),
        .rd_valid (qs_valid),
        .rd_ready (qs_ready),
        .rd_color (qs_color)
    );

    ws2_serial u_serial (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .timing          (timing_reg),
        .q_valid         (qs_valid),
        .q_ready         (qs_ready),
        .q_color         (qs_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_level    (m_line_level),
        .m_segment_ticks (m_segment_ticks),
        .m_frame_end     (m_frame_end)
    );

endmodule

`default_nettype wire

// File: rtl/ws2_checker.sv
// Port-level checks for the WS2812 pulse encoder, bound to the top level.
// Depends on ws2_pkg and ws2812_pulse_encoder.
`timescale 1ns / 1ps
`default_nettype none

module ws2_checker
    import ws2_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_line_level,
    input wire logic [GAP_TICK_W-1:0] m_segment_ticks,
    input wire logic                  m_frame_end
);

    // A stalled segment keeps its value until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_level)
            && $stable(m_segment_ticks) && $stable(m_frame_end))
        else $error("stalled segment changed");

    // The latch segment at the end of a frame is low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> !m_line_level)
        else $error("frame end segment is high");

    // No segment ever has zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_segment_ticks != '0)
        else $error("zero-length segment");

    // The low half of a bit follows its high half in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_line_level |=> m_valid && !m_line_level && !m_frame_end)
        else $error("high segment not followed by low segment");

    // Reset leaves the result channel empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ws2812_pulse_encoder ws2_checker u_ws2_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_line_level    (m_line_level),
    .m_segment_ticks (m_segment_ticks),
    .m_frame_end     (m_frame_end)
);

`default_nettype wire
